// ===== hw/rtl/bcd_date_check_weekday_dst_core_macros.svh =====
// assertion macros for the bcd date checker
`ifndef BCD_DATE_CHECK_WEEKDAY_DST_CORE_MACROS_SVH
`define BCD_DATE_CHECK_WEEKDAY_DST_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BDCWD_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed in bcd date checker");
`define BDCWD_ASSERT(lbl, prop) `BDCWD_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)
`else
`define BDCWD_ASSERT_CLK(lbl, clk, rstn, prop)
`define BDCWD_ASSERT(lbl, prop)
`endif

`endif

// ===== hw/rtl/bdcwd_pkg.sv =====
`timescale 1ns / 1ps

package bdcwd_pkg;

    localparam int unsigned InBytes  = 6;
    localparam int unsigned InWidth  = InBytes * 8;
    // 6 bytes + weekday(3) + corrected(1) + dst action(2) = 54, padded to 56
    localparam int unsigned OutWidth = 56;

    typedef enum logic [1:0] {
        DST_NONE = 2'd0,
        DST_FWD  = 2'd1,
        DST_BACK = 2'd2
    } t_dst_action;

    localparam logic [2:0] WD_SUNDAY = 3'd7;

    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [7:0] date;
        logic [7:0] month;
        logic [7:0] year;
        logic       fix;
    } t_stamp;

    // binary value of two nibbles, a nibble above 9 keeps its binary weight
    function automatic logic [7:0] bcd_val(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
    endfunction

    // floor(31 * m / 12) for the shifted month m of the month value 1..12
    function automatic logic [5:0] month_offset(input logic [3:0] mv);
        logic [5:0] r;
        case (mv)
            4'd1:    r = 6'd28;
            4'd2:    r = 6'd31;
            4'd3:    r = 6'd2;
            4'd4:    r = 6'd5;
            4'd5:    r = 6'd7;
            4'd6:    r = 6'd10;
            4'd7:    r = 6'd12;
            4'd8:    r = 6'd15;
            4'd9:    r = 6'd18;
            4'd10:   r = 6'd20;
            4'd11:   r = 6'd23;
            4'd12:   r = 6'd25;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/bcd_date_check_weekday_dst_core.sv =====
`timescale 1ns / 1ps
`include "bcd_date_check_weekday_dst_core_macros.svh"
// channel   | direction | payload
// s_axis    | in        | tdata: sec, min, hour, date, month, year (8 bits each)
// m_axis    | out       | tdata: six repaired bytes, weekday, corrected, dst action
// cfg       | in        | data: dst_enable
//
// four register stages, one timestamp per clock while m_axis_tready holds
// stage 1 field repair, stage 2 month length, month repair and year term, stage 3 weekday sum,
// stage 4 mod-7 fold, weekday and hour shift into the output register
// each stage holds its word when the next one is full, so a stall drops nothing
// reset clears the stage valid bits and dst_enable; cfg is always ready

module bcd_date_check_weekday_dst_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sec, min, hour, date, month, year
    input  logic [bdcwd_pkg::InWidth-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sec_out, min_out, hour_out, date_out, month_out, year_out, weekday_out,
    // was_corrected, dst_action, zero pad
    output logic [bdcwd_pkg::OutWidth-1:0]  m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [0:0]                      i_cfg_data
);
    import bdcwd_pkg::*;

    logic r_dst_en;
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    t_stamp     r1_st, n1_st;
    logic [4:0] r1_dv, n1_dv;
    logic [7:0] r1_mv, n1_mv;
    logic [7:0] r1_yv, n1_yv;
    logic       r1_leap, n1_leap;

    t_stamp     r2_st, n2_st;
    logic [4:0] r2_dv, n2_dv;
    logic [3:0] r2_mv, n2_mv;
    logic [7:0] r2_part, n2_part;

    t_stamp     r3_st;
    logic [4:0] r3_dv;
    logic [3:0] r3_mv;
    logic [4:0] r3_fold, n3_fold;

    t_stamp      r4_st, n4_st;
    logic [2:0]  r4_wd, n4_wd;
    t_dst_action r4_act, n4_act;

    // handshake chain
    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {2'b00, r4_act, r4_st.fix, r4_wd, r4_st.year, r4_st.month,
                            r4_st.date, r4_st.hour, r4_st.min, r4_st.sec};

    // stage 1: decode and plain range repair
    always_comb begin
        logic [7:0] sv, mnv, hv, dv;
        sv  = bcd_val(s_axis_tdata[7:0]);
        mnv = bcd_val(s_axis_tdata[15:8]);
        hv  = bcd_val(s_axis_tdata[23:16]);
        dv  = bcd_val(s_axis_tdata[31:24]);
        n1_st.sec   = s_axis_tdata[7:0];
        n1_st.min   = s_axis_tdata[15:8];
        n1_st.hour  = s_axis_tdata[23:16];
        n1_st.date  = s_axis_tdata[31:24];
        n1_st.month = s_axis_tdata[39:32];
        n1_st.year  = s_axis_tdata[47:40];
        n1_st.fix   = 1'b0;
        n1_dv       = dv[4:0];
        if (sv > 8'd59) begin
            n1_st.sec = 8'h00;
            n1_st.fix = 1'b1;
        end
        if (mnv > 8'd59) begin
            n1_st.min = 8'h00;
            n1_st.fix = 1'b1;
        end
        if (hv > 8'd23) begin
            n1_st.hour = 8'h00;
            n1_st.fix  = 1'b1;
        end
        if (dv == 8'd0 || dv > 8'd31) begin
            n1_st.date = 8'h01;
            n1_dv      = 5'd1;
            n1_st.fix  = 1'b1;
        end
        n1_mv   = bcd_val(s_axis_tdata[39:32]);
        n1_yv   = bcd_val(s_axis_tdata[47:40]);
        // years 2000..2165: only 2100 breaks the divide-by-four rule
        n1_leap = (n1_yv[1:0] == 2'b00) && (n1_yv != 8'd100);
    end

    // stage 2: month length, month repair, year part of the congruence
    always_comb begin
        logic       jan_feb;
        logic [7:0] yy, s;
        n2_st = r1_st;
        n2_dv = r1_dv;
        if (r1_mv == 8'd2) begin
            if (r1_leap && r1_dv > 5'd29) begin
                n2_st.date = 8'h29;
                n2_dv      = 5'd29;
                n2_st.fix  = 1'b1;
            end else if (!r1_leap && r1_dv > 5'd28) begin
                n2_st.date = 8'h28;
                n2_dv      = 5'd28;
                n2_st.fix  = 1'b1;
            end
        end else if (r1_mv == 8'd4 || r1_mv == 8'd6 || r1_mv == 8'd9 || r1_mv == 8'd11) begin
            if (r1_dv > 5'd30) begin
                n2_st.date = 8'h30;
                n2_dv      = 5'd30;
                n2_st.fix  = 1'b1;
            end
        end
        if (r1_mv == 8'd0 || r1_mv > 8'd12) begin
            n2_st.month = 8'h01;
            n2_mv       = 4'd1;
            n2_st.fix   = 1'b1;
        end else begin
            n2_mv = r1_mv[3:0];
        end
        jan_feb = (n2_mv <= 4'd2);
        // yy = y - 1999, y + y/4 - y/100 + y/400 = 2483 + yy + (yy+3)/4 - (yy > 100)
        yy = r1_yv + 8'd1 - {7'b0, jan_feb};
        s  = yy + ((yy + 8'd3) >> 2);
        // 2483 mod 7 = 5
        n2_part = 8'd5 + s - {7'b0, (yy > 8'd100)};
    end

    // stage 3: weekday sum, first octal fold (8 = 1 mod 7)
    always_comb begin
        logic [8:0] x;
        x = {4'b0, r2_dv} + {1'b0, r2_part} + {3'b0, month_offset(r2_mv)};
        n3_fold = {2'b0, x[8:6]} + {2'b0, x[5:3]} + {2'b0, x[2:0]};
    end

    // stage 4: finish mod 7, weekday and hour shift
    always_comb begin
        logic [3:0] f;
        logic [2:0] d;
        logic       sunday_end;
        f = {2'b0, r3_fold[4:3]} + {1'b0, r3_fold[2:0]};
        d = (f >= 4'd7) ? 3'(f - 4'd7) : f[2:0];
        n4_wd  = (d == 3'd0) ? WD_SUNDAY : d;
        n4_st  = r3_st;
        n4_act = DST_NONE;
        sunday_end = r_dst_en && (r3_dv >= 5'd25) && (n4_wd == WD_SUNDAY) &&
                     (r3_st.min == 8'h00) && (r3_st.sec == 8'h00);
        if (sunday_end) begin
            if (r3_mv == 4'd3 && r3_st.hour == 8'h02) begin
                n4_st.hour = 8'h03;
                n4_act     = DST_FWD;
            end else if (r3_mv == 4'd10 && r3_st.hour == 8'h03) begin
                n4_st.hour = 8'h02;
                n4_act     = DST_BACK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_en <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dst_en <= i_cfg_data[0];
            end
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_st   <= n1_st;
            r1_dv   <= n1_dv;
            r1_mv   <= n1_mv;
            r1_yv   <= n1_yv;
            r1_leap <= n1_leap;
        end
        if (en2) begin
            r2_st   <= n2_st;
            r2_dv   <= n2_dv;
            r2_mv   <= n2_mv;
            r2_part <= n2_part;
        end
        if (en3) begin
            r3_st   <= r2_st;
            r3_dv   <= r2_dv;
            r3_mv   <= r2_mv;
            r3_fold <= n3_fold;
        end
        if (en4) begin
            r4_st  <= n4_st;
            r4_wd  <= n4_wd;
            r4_act <= n4_act;
        end
    end

    `BDCWD_ASSERT(a_accept_fills_stage1, s_axis_tvalid && s_axis_tready |=> r_v1)
    `BDCWD_ASSERT(a_weekday_nonzero, r_v4 |-> r4_wd != 3'd0)
    `BDCWD_ASSERT(a_fwd_shape,
        r_v4 && r4_act == DST_FWD |-> r4_st.month == 8'h03 && r4_st.hour == 8'h03 && r_dst_en)
    // october may arrive with a non-decimal low nibble, so compare the value
    `BDCWD_ASSERT(a_back_shape,
        r_v4 && r4_act == DST_BACK |->
        bcd_val(r4_st.month) == 8'd10 && r4_st.hour == 8'h02 && r_dst_en)
    `BDCWD_ASSERT(a_shift_on_sunday, r_v4 && r4_act != DST_NONE |-> r4_wd == WD_SUNDAY)

endmodule
